[rtl/core/ctht_pkg.sv]
// Shared types and constants for the connection table.
`timescale 1ns / 1ps

package ctht_pkg;

   localparam int KIND_W  = 3;
   localparam int SOCK_W  = 4;
   localparam int PORT_W  = 16;
   localparam int SEG_W   = 3;
   localparam int ENTRY_W = 4;
   localparam int RETRY_W = 4;
   localparam int CSR_IDX_W = 2;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_OPEN       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CONNECT    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DISCONNECT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLOSE      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ARRIVAL    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_TICK       = 3'd5;

   // Arriving segment types that move the state.
   localparam logic [SEG_W-1:0] SEG_SYNACK = 3'd1;
   localparam logic [SEG_W-1:0] SEG_FINACK = 3'd3;

   // Transmitted segment types.
   localparam logic SEND_SYN = 1'b0;
   localparam logic SEND_FIN = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SYN_RETRY_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIN_RETRY_LIMIT = 2'd1;
   localparam logic [RETRY_W-1:0]   RETRY_LIMIT_RESET   = 4'd5;

   typedef enum logic [1:0] {
      CS_CLOSED    = 2'd0,
      CS_SYNSENT   = 2'd1,
      CS_CONNECTED = 2'd2,
      CS_FINWAIT   = 2'd3
   } conn_state_type;

   typedef enum logic [1:0] {
      OP_NONE       = 2'd0,
      OP_CONNECT    = 2'd1,
      OP_DISCONNECT = 2'd2
   } pend_op_type;

   typedef enum logic [1:0] {
      ST_PENDING = 2'd0,
      ST_OK      = 2'd1,
      ST_FAIL    = 2'd2,
      ST_NOMATCH = 2'd3
   } status_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SOCK_W-1:0] socket_index;
      logic [PORT_W-1:0] port;
      logic [SEG_W-1:0]  segment_type;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [ENTRY_W-1:0] entry_index;
      logic               send_valid;
      logic               send_type;
      logic [PORT_W-1:0]  send_source_port;
      logic [PORT_W-1:0]  send_dest_port;
   } rsp_type;

   typedef struct packed {
      logic [RETRY_W-1:0] syn_retry_limit;
      logic [RETRY_W-1:0] fin_retry_limit;
   } cfg_type;

   // What travels from cell to cell: the request, a claimed mark and the
   // result built so far.
   typedef struct packed {
      req_type req;
      logic    done;
      rsp_type rsp;
   } token_type;

endpackage

[rtl/core/ctht_cell.sv]
// One table entry: holds its connection state and acts on the passing token.
`timescale 1ns / 1ps

module ctht_cell
   import ctht_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      tok_valid_in,
   input  token_type tok_in,
   output logic      tok_valid_out,
   output token_type tok_out
);

   logic               used_ff,  used_in;
   logic [PORT_W-1:0]  lport_ff, lport_in;
   logic [PORT_W-1:0]  rport_ff, rport_in;
   conn_state_type     cst_ff,   cst_in;
   pend_op_type        pop_ff,   pop_in;
   logic [RETRY_W-1:0] retry_ff, retry_in;
   logic               tok_valid_ff;
   token_type          tok_ff,   tok_in_nx;

   logic               sock_hit;
   logic               port_hit;
   conn_state_type     goal;
   logic [RETRY_W-1:0] limit;
   logic               seg_kind;

   assign sock_hit = (INDEX < (1 << SOCK_W)) && (tok_in.req.socket_index == SOCK_W'(INDEX));
   assign port_hit = used_ff && (lport_ff == tok_in.req.port);

   always_comb begin
      if (pop_ff == OP_CONNECT) begin
         goal     = CS_CONNECTED;
         limit    = cfg.syn_retry_limit;
         seg_kind = SEND_SYN;
      end else begin
         goal     = CS_CLOSED;
         limit    = cfg.fin_retry_limit;
         seg_kind = SEND_FIN;
      end
   end

   always_comb begin
      used_in   = used_ff;
      lport_in  = lport_ff;
      rport_in  = rport_ff;
      cst_in    = cst_ff;
      pop_in    = pop_ff;
      retry_in  = retry_ff;
      tok_in_nx = tok_in;

      if (tok_valid_in && !tok_in.done) begin
         unique case (tok_in.req.kind)
            KIND_OPEN: begin
               if (!used_ff) begin
                  used_in  = 1'b1;
                  lport_in = tok_in.req.port;
                  rport_in = '0;
                  cst_in   = CS_CLOSED;
                  pop_in   = OP_NONE;
                  retry_in = '0;
                  tok_in_nx.done            = 1'b1;
                  tok_in_nx.rsp.status      = ST_OK;
                  tok_in_nx.rsp.entry_index = ENTRY_W'(INDEX);
               end
            end
            KIND_ARRIVAL: begin
               if (port_hit) begin
                  tok_in_nx.done            = 1'b1;
                  tok_in_nx.rsp.entry_index = ENTRY_W'(INDEX);
                  tok_in_nx.rsp.status      = ST_PENDING;
                  if (tok_in.req.segment_type == SEG_SYNACK && cst_ff == CS_SYNSENT) begin
                     cst_in               = CS_CONNECTED;
                     tok_in_nx.rsp.status = ST_OK;
                  end else if (tok_in.req.segment_type == SEG_FINACK &&
                               cst_ff == CS_FINWAIT) begin
                     cst_in               = CS_CLOSED;
                     tok_in_nx.rsp.status = ST_OK;
                  end
               end
            end
            KIND_CONNECT: begin
               if (sock_hit && used_ff) begin
                  tok_in_nx.done = 1'b1;
                  rport_in = tok_in.req.port;
                  cst_in   = CS_SYNSENT;
                  pop_in   = OP_CONNECT;
                  retry_in = '0;
                  tok_in_nx.rsp.status           = ST_PENDING;
                  tok_in_nx.rsp.send_valid       = 1'b1;
                  tok_in_nx.rsp.send_type        = SEND_SYN;
                  tok_in_nx.rsp.send_source_port = lport_ff;
                  tok_in_nx.rsp.send_dest_port   = tok_in.req.port;
               end
            end
            KIND_DISCONNECT: begin
               if (sock_hit && used_ff) begin
                  tok_in_nx.done = 1'b1;
                  cst_in   = CS_FINWAIT;
                  pop_in   = OP_DISCONNECT;
                  retry_in = '0;
                  tok_in_nx.rsp.status           = ST_PENDING;
                  tok_in_nx.rsp.send_valid       = 1'b1;
                  tok_in_nx.rsp.send_type        = SEND_FIN;
                  tok_in_nx.rsp.send_source_port = lport_ff;
                  tok_in_nx.rsp.send_dest_port   = rport_ff;
               end
            end
            KIND_CLOSE: begin
               if (sock_hit && used_ff) begin
                  tok_in_nx.done       = 1'b1;
                  tok_in_nx.rsp.status = (cst_ff == CS_CLOSED) ? ST_OK : ST_FAIL;
                  used_in  = 1'b0;
                  cst_in   = CS_CLOSED;
                  pop_in   = OP_NONE;
                  retry_in = '0;
               end
            end
            KIND_TICK: begin
               if (sock_hit && used_ff) begin
                  tok_in_nx.done = 1'b1;
                  if (pop_ff == OP_NONE) begin
                     tok_in_nx.rsp.status = ST_PENDING;
                  end else if (cst_ff == goal) begin
                     pop_in               = OP_NONE;
                     tok_in_nx.rsp.status = ST_OK;
                  end else if (retry_ff >= limit) begin
                     cst_in               = CS_CLOSED;
                     pop_in               = OP_NONE;
                     tok_in_nx.rsp.status = ST_FAIL;
                  end else begin
                     retry_in = retry_ff + RETRY_W'(1);
                     tok_in_nx.rsp.status           = ST_PENDING;
                     tok_in_nx.rsp.send_valid       = 1'b1;
                     tok_in_nx.rsp.send_type        = seg_kind;
                     tok_in_nx.rsp.send_source_port = lport_ff;
                     tok_in_nx.rsp.send_dest_port   = rport_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= 1'b0;
         cst_ff       <= CS_CLOSED;
         pop_ff       <= OP_NONE;
         retry_ff     <= '0;
         tok_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         cst_ff       <= cst_in;
         pop_ff       <= pop_in;
         retry_ff     <= retry_in;
         tok_valid_ff <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lport_ff <= lport_in;
      rport_ff <= rport_in;
      tok_ff   <= tok_in_nx;
   end

   assign tok_valid_out = tok_valid_ff;
   assign tok_out       = tok_ff;

endmodule

[rtl/core/connection_table_handshake_fsm.sv]
// Top level of the connection table: request intake, cell row and result buffering.
`timescale 1ns / 1ps

// Each accepted beat walks the row of ENTRIES cells, one cell per cycle. The
// block works on one item at a time, so a new beat is taken once the
// previous one has left the row. Open claims the first free entry on the
// way and an arriving segment the first used entry with its local port.
// One finished result may wait in a spare register while another sits on
// the result port; while both are held the request side stalls too.
// Configuration writes are always ready and must be made while the block is
// idle. There is no clearing pass after reset.
module connection_table_handshake_fsm
   import ctht_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RETRY_W-1:0]   csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      busy_ff, busy_in;
   logic      hold_valid_ff, hold_valid_in;
   token_type hold_ff, hold_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;

   logic      accept;
   logic      take;
   token_type start_tok;
   logic      tok_valid [ENTRIES+1];
   token_type tok       [ENTRIES+1];

   assign csr_ready = 1'b1;
   assign req_stall = busy_ff | hold_valid_ff;
   assign accept    = req_valid & ~req_stall;
   assign take      = rsp_valid_ff & ~rsp_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SYN_RETRY_LIMIT: cfg_in.syn_retry_limit = csr_wdata;
            CSR_FIN_RETRY_LIMIT: cfg_in.fin_retry_limit = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The result starts at the answer given when no cell claims the beat.
   always_comb begin
      start_tok      = '0;
      start_tok.req  = req_data;
      start_tok.done = 1'b0;
      unique case (req_data.kind) inside
         KIND_OPEN, KIND_CONNECT, KIND_DISCONNECT, KIND_CLOSE, KIND_TICK:
            start_tok.rsp.status = ST_FAIL;
         KIND_ARRIVAL:
            start_tok.rsp.status = ST_NOMATCH;
         default:
            start_tok.rsp.status = ST_PENDING;
      endcase
   end

   assign tok_valid[0] = accept;
   assign tok[0]       = start_tok;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      ctht_cell #(
         .INDEX (g)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cfg           (cfg_ff),
         .tok_valid_in  (tok_valid[g]),
         .tok_in        (tok[g]),
         .tok_valid_out (tok_valid[g+1]),
         .tok_out       (tok[g+1])
      );
   end

   always_comb begin
      busy_in       = busy_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      if (accept) begin
         busy_in = 1'b1;
      end else if (tok_valid[ENTRIES]) begin
         busy_in = 1'b0;
      end

      if (!rsp_valid_ff || take) begin
         if (hold_valid_ff) begin
            rsp_in        = hold_ff.rsp;
            rsp_valid_in  = 1'b1;
            hold_valid_in = 1'b0;
         end else if (tok_valid[ENTRIES]) begin
            rsp_in       = tok[ENTRIES].rsp;
            rsp_valid_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (tok_valid[ENTRIES]) begin
         hold_in       = tok[ENTRIES];
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.syn_retry_limit <= RETRY_LIMIT_RESET;
         cfg_ff.fin_retry_limit <= RETRY_LIMIT_RESET;
         busy_ff                <= 1'b0;
         hold_valid_ff          <= 1'b0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         busy_ff       <= busy_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[test/connection_table_handshake_fsm_checker.sv]
// Checker for the connection table: predicts every result beat and compares it field by field.
`timescale 1ns / 1ps

module connection_table_handshake_fsm_checker
   import ctht_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RETRY_W-1:0]   csr_wdata,
   output int                   outstanding,
   output int                   mismatch_count
);

   logic [RETRY_W-1:0] syn_limit;
   logic [RETRY_W-1:0] fin_limit;

   logic               entry_used  [ENTRIES];
   logic [PORT_W-1:0]  local_port  [ENTRIES];
   logic [PORT_W-1:0]  remote_port [ENTRIES];
   conn_state_type     conn_state  [ENTRIES];
   pend_op_type        pending     [ENTRIES];
   logic [RETRY_W-1:0] retries     [ENTRIES];

   rsp_type expected_rsp_q[$];
   rsp_type want;
   int      errors = 0;

   assign mismatch_count = errors;

   task automatic report_mismatch(input string what);
      $display("[%0t] checker: %s", $time, what);
      errors++;
   endtask

   function automatic rsp_type with_send(input rsp_type r, input int idx, input logic seg);
      rsp_type o;
      o = r;
      o.send_valid       = 1'b1;
      o.send_type        = seg;
      o.send_source_port = local_port[idx];
      o.send_dest_port   = remote_port[idx];
      return o;
   endfunction

   // Applies one command to the shadow table and returns the result it must produce.
   function automatic rsp_type predict_table(input req_type r);
      rsp_type            res;
      int                 s;
      logic               sock_ok;
      logic               found;
      conn_state_type     goal;
      logic [RETRY_W-1:0] limit;
      logic               seg;
      res     = '0;
      s       = int'(r.socket_index);
      sock_ok = (s < ENTRIES) ? entry_used[s] : 1'b0;
      found   = 1'b0;
      case (r.kind)
         KIND_OPEN: begin
            res.status = ST_FAIL;
            for (int i = 0; i < ENTRIES; i++) begin
               if (!found && !entry_used[i]) begin
                  found          = 1'b1;
                  entry_used[i]  = 1'b1;
                  local_port[i]  = r.port;
                  remote_port[i] = '0;
                  conn_state[i]  = CS_CLOSED;
                  pending[i]     = OP_NONE;
                  retries[i]     = '0;
                  res.status      = ST_OK;
                  res.entry_index = i[ENTRY_W-1:0];
               end
            end
         end
         KIND_CONNECT: begin
            if (!sock_ok) begin
               res.status = ST_FAIL;
            end else begin
               remote_port[s] = r.port;
               conn_state[s]  = CS_SYNSENT;
               pending[s]     = OP_CONNECT;
               retries[s]     = '0;
               res = with_send(res, s, SEND_SYN);
               res.status = ST_PENDING;
            end
         end
         KIND_DISCONNECT: begin
            if (!sock_ok) begin
               res.status = ST_FAIL;
            end else begin
               conn_state[s] = CS_FINWAIT;
               pending[s]    = OP_DISCONNECT;
               retries[s]    = '0;
               res = with_send(res, s, SEND_FIN);
               res.status = ST_PENDING;
            end
         end
         KIND_CLOSE: begin
            if (!sock_ok) begin
               res.status = ST_FAIL;
            end else begin
               res.status    = (conn_state[s] == CS_CLOSED) ? ST_OK : ST_FAIL;
               entry_used[s] = 1'b0;
               conn_state[s] = CS_CLOSED;
               pending[s]    = OP_NONE;
               retries[s]    = '0;
            end
         end
         KIND_ARRIVAL: begin
            res.status = ST_NOMATCH;
            for (int i = 0; i < ENTRIES; i++) begin
               if (!found && entry_used[i] && local_port[i] == r.port) begin
                  found           = 1'b1;
                  res.entry_index = i[ENTRY_W-1:0];
                  res.status      = ST_PENDING;
                  if (r.segment_type == SEG_SYNACK && conn_state[i] == CS_SYNSENT) begin
                     conn_state[i] = CS_CONNECTED;
                     res.status    = ST_OK;
                  end else if (r.segment_type == SEG_FINACK && conn_state[i] == CS_FINWAIT) begin
                     conn_state[i] = CS_CLOSED;
                     res.status    = ST_OK;
                  end
               end
            end
         end
         KIND_TICK: begin
            if (!sock_ok) begin
               res.status = ST_FAIL;
            end else if (pending[s] != OP_NONE) begin
               if (pending[s] == OP_CONNECT) begin
                  goal  = CS_CONNECTED;
                  limit = syn_limit;
                  seg   = SEND_SYN;
               end else begin
                  goal  = CS_CLOSED;
                  limit = fin_limit;
                  seg   = SEND_FIN;
               end
               if (conn_state[s] == goal) begin
                  pending[s] = OP_NONE;
                  res.status = ST_OK;
               end else if (retries[s] >= limit) begin
                  conn_state[s] = CS_CLOSED;
                  pending[s]    = OP_NONE;
                  res.status    = ST_FAIL;
               end else begin
                  retries[s] = retries[s] + RETRY_W'(1);
                  res = with_send(res, s, seg);
                  res.status = ST_PENDING;
               end
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         syn_limit <= RETRY_LIMIT_RESET;
         fin_limit <= RETRY_LIMIT_RESET;
         for (int i = 0; i < ENTRIES; i++) begin
            entry_used[i]  = 1'b0;
            local_port[i]  = '0;
            remote_port[i] = '0;
            conn_state[i]  = CS_CLOSED;
            pending[i]     = OP_NONE;
            retries[i]     = '0;
         end
         expected_rsp_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SYN_RETRY_LIMIT: syn_limit <= csr_wdata;
               CSR_FIN_RETRY_LIMIT: fin_limit <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch($sformatf("result beat %h with nothing expected", rsp_data));
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.entry_index !== want.entry_index)
                  report_mismatch($sformatf("entry_index %0d, expected %0d",
                                            rsp_data.entry_index, want.entry_index));
               if (rsp_data.send_valid !== want.send_valid)
                  report_mismatch($sformatf("send_valid %0b, expected %0b",
                                            rsp_data.send_valid, want.send_valid));
               if (rsp_data.send_type !== want.send_type)
                  report_mismatch($sformatf("send_type %0b, expected %0b",
                                            rsp_data.send_type, want.send_type));
               if (rsp_data.send_source_port !== want.send_source_port)
                  report_mismatch($sformatf("send_source_port %h, expected %h",
                                            rsp_data.send_source_port, want.send_source_port));
               if (rsp_data.send_dest_port !== want.send_dest_port)
                  report_mismatch($sformatf("send_dest_port %h, expected %h",
                                            rsp_data.send_dest_port, want.send_dest_port));
            end
         end
         if (req_valid && !req_stall) begin
            expected_rsp_q.push_back(predict_table(req_data));
         end
      end
      outstanding <= expected_rsp_q.size();
   end

endmodule

[test/connection_table_handshake_fsm_tb.sv]
// Testbench top for the connection table: clock, reset, command stimulus and the verdict.
`timescale 1ns / 1ps

module connection_table_handshake_fsm_tb;
   import ctht_pkg::*;

   localparam int ENTRIES      = 16;
   localparam int DRAIN_CYCLES = ENTRIES + 8;
   localparam int CYCLE_LIMIT  = 200000;

   // Codes that the package leaves unnamed.
   localparam logic [KIND_W-1:0] KIND_RESERVED_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_RESERVED_B = 3'd7;
   localparam logic [SEG_W-1:0]  SEG_SYN         = 3'd0;
   localparam logic [SEG_W-1:0]  SEG_FIN         = 3'd2;
   localparam logic [SEG_W-1:0]  SEG_OTHER       = 3'd4;
   localparam logic [SEG_W-1:0]  SEG_RESERVED_A  = 3'd5;
   localparam logic [SEG_W-1:0]  SEG_RESERVED_B  = 3'd7;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   req_type              req_data  = '0;
   logic                 rsp_stall = 1'b0;
   logic                 csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [RETRY_W-1:0]   csr_wdata = '0;
   logic                 req_stall;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_ready;

   int outstanding;
   int mismatch_count;
   int cycle_count = 0;
   int items_sent  = 0;
   bit quiet       = 1'b0;
   int syn_limit_now;
   int fin_limit_now;

   // Rough view of which sockets are open, used only to steer the stimulus.
   bit                sock_open [ENTRIES];
   logic [PORT_W-1:0] sock_port [ENTRIES];
   logic [PORT_W-1:0] port_pool [8];

   connection_table_handshake_fsm #(.ENTRIES(ENTRIES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   connection_table_handshake_fsm_checker #(.ENTRIES(ENTRIES)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .outstanding    (outstanding),
      .mismatch_count (mismatch_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 12);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Valid is left high after a beat is taken so that back-to-back beats never
   // lower and raise it in the same step; the next call or a drain decides.
   task automatic send_req(input logic [KIND_W-1:0] kind, input int sock,
                           input logic [PORT_W-1:0] port, input logic [SEG_W-1:0] seg);
      req_type r;
      bit      found;
      r.kind         = kind;
      r.socket_index = sock[SOCK_W-1:0];
      r.port         = port;
      r.segment_type = seg;
      found          = 1'b0;
      while (!quiet && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (kind == KIND_OPEN) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (!found && !sock_open[i]) begin
               found        = 1'b1;
               sock_open[i] = 1'b1;
               sock_port[i] = port;
            end
         end
      end else if (kind == KIND_CLOSE) begin
         sock_open[r.socket_index] = 1'b0;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limits(input int syn, input int fin);
      csr_valid <= 1'b1;
      csr_index <= CSR_SYN_RETRY_LIMIT;
      csr_wdata <= syn[RETRY_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_FIN_RETRY_LIMIT;
      csr_wdata <= fin[RETRY_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      syn_limit_now = syn;
      fin_limit_now = fin;
      @(posedge clock);
   endtask

   function automatic int pick_socket();
      int cands[$];
      for (int i = 0; i < ENTRIES; i++) begin
         if (sock_open[i]) cands.push_back(i);
      end
      if (cands.size() == 0 || $urandom_range(0, 99) < 10) return $urandom_range(0, ENTRIES - 1);
      return cands[$urandom_range(0, cands.size() - 1)];
   endfunction

   function automatic logic [PORT_W-1:0] pick_port();
      if ($urandom_range(0, 99) < 70) return port_pool[$urandom_range(0, 7)];
      return PORT_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [SEG_W-1:0] rand_seg();
      return SEG_W'($urandom_range(0, 7));
   endfunction

   function automatic logic [PORT_W-1:0] rand_port();
      return PORT_W'($urandom_range(0, 65535));
   endfunction

   // Mostly well-formed handshakes on open sockets, with opens, closes,
   // stray arrivals and fully random commands mixed in.
   task automatic random_phase(input int count, input int open_pct);
      int   start;
      int   s;
      int   roll;
      int   n;
      int   ack_at;
      int   limit;
      bit   conn;
      logic [SEG_W-1:0] ack_seg;
      start = items_sent;
      while (items_sent - start < count) begin
         roll = $urandom_range(0, 99);
         s    = pick_socket();
         if (roll < open_pct) begin
            send_req(KIND_OPEN, $urandom_range(0, 15), pick_port(), rand_seg());
         end else if (roll < open_pct + 25) begin
            conn    = 1'($urandom_range(0, 1));
            limit   = conn ? syn_limit_now : fin_limit_now;
            ack_seg = conn ? SEG_SYNACK : SEG_FINACK;
            if ($urandom_range(0, 99) < 20) ack_seg = rand_seg();
            send_req(conn ? KIND_CONNECT : KIND_DISCONNECT, s, pick_port(), rand_seg());
            // Some handshakes tick past the retry limit to reach the give-up path.
            n      = ($urandom_range(0, 99) < 20) ? limit + 2 : $urandom_range(0, 3);
            ack_at = ($urandom_range(0, 99) < 65) ? $urandom_range(0, n) : -1;
            for (int k = 0; k <= n; k++) begin
               if (k == ack_at) begin
                  send_req(KIND_ARRIVAL, $urandom_range(0, 15), sock_port[s], ack_seg);
               end
               send_req(KIND_TICK, s, rand_port(), rand_seg());
            end
         end else if (roll < open_pct + 33) begin
            send_req(KIND_CLOSE, s, rand_port(), rand_seg());
         end else if (roll < open_pct + 41) begin
            send_req(KIND_ARRIVAL, $urandom_range(0, 15), pick_port(), rand_seg());
         end else if (roll < open_pct + 47) begin
            send_req(KIND_W'($urandom_range(0, 7)), $urandom_range(0, 15), rand_port(),
                     rand_seg());
         end else begin
            send_req(KIND_TICK, s, rand_port(), rand_seg());
         end
      end
   endtask

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         sock_open[i] = 1'b0;
         sock_port[i] = '0;
      end
      port_pool[0] = 16'h0000;
      port_pool[1] = 16'hFFFF;
      for (int i = 2; i < 8; i++) begin
         port_pool[i] = rand_port();
      end
      syn_limit_now = int'(RETRY_LIMIT_RESET);
      fin_limit_now = int'(RETRY_LIMIT_RESET);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Commands on sockets that were never opened.
      send_req(KIND_TICK, 0, 16'h0000, SEG_SYN);
      send_req(KIND_CONNECT, 15, 16'hFFFF, SEG_RESERVED_B);
      send_req(KIND_CLOSE, 3, 16'h0000, SEG_SYN);
      // Entries 0 and 2 share a local port; 1 uses port zero.
      send_req(KIND_OPEN, 9, 16'hFFFF, SEG_SYN);
      send_req(KIND_OPEN, 0, 16'h0000, SEG_RESERVED_B);
      send_req(KIND_OPEN, 0, 16'hFFFF, SEG_SYN);
      send_req(KIND_ARRIVAL, 0, 16'h1234, SEG_SYNACK);
      send_req(KIND_CONNECT, 0, 16'hA5C3, SEG_SYN);
      send_req(KIND_TICK, 0, 16'h0000, SEG_SYN);
      send_req(KIND_ARRIVAL, 0, 16'hFFFF, SEG_FINACK);
      send_req(KIND_ARRIVAL, 0, 16'hFFFF, SEG_SYNACK);
      send_req(KIND_TICK, 0, 16'h0000, SEG_SYN);
      send_req(KIND_TICK, 0, 16'h0000, SEG_SYN);
      send_req(KIND_CLOSE, 0, 16'h0000, SEG_SYN);
      send_req(KIND_DISCONNECT, 1, 16'hFFFF, SEG_FIN);
      send_req(KIND_ARRIVAL, 0, 16'h0000, SEG_FINACK);
      send_req(KIND_TICK, 1, 16'h0000, SEG_SYN);
      send_req(KIND_CLOSE, 1, 16'h0000, SEG_SYN);
      // A connect that never completes: resends up to the limit, then gives up.
      send_req(KIND_CONNECT, 2, 16'h5A3C, SEG_OTHER);
      repeat (RETRY_LIMIT_RESET + 1) send_req(KIND_TICK, 2, 16'h0000, SEG_SYN);
      send_req(KIND_RESERVED_A, 2, 16'hFFFF, SEG_RESERVED_B);
      send_req(KIND_RESERVED_B, 15, 16'h0000, SEG_RESERVED_A);

      drain();
      write_limits(0, 15);
      random_phase(150, 15);
      drain();
      write_limits(15, 0);
      quiet = 1'b1;
      random_phase(150, 15);
      drain();
      quiet = 1'b0;
      write_limits(3, 7);
      random_phase(150, 45);
      drain();
      write_limits($urandom_range(1, 14), $urandom_range(1, 14));
      random_phase(150, 15);
      drain();
      write_limits(15, 15);
      random_phase(120, 5);
      drain();

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
